FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the six-step commutator.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check on every rising clk edge, ignored while arst_n is low
`define ASSERT_CLKRST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every rising clk edge, reset included
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKRST(lbl, prop, msg)
`define ASSERT_CLK(lbl, prop, msg)

`endif

`endif

FILE: rtl/bldc_pkg.sv
// Shared types and constants of the six-step commutator.
// No dependencies; used by the interface users, bldc_commute and the top level.
`timescale 1ns / 1ps

package bldc_pkg;

	localparam int DUTY_W     = 14;
	localparam int POT_W      = 12;
	localparam int HALL_W     = 3;
	localparam int FUNC_W     = 2;
	localparam int STEP_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OC_DROP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY  = 2'd3;

	// configuration reset values
	localparam logic [DUTY_W-1:0] CUTOFF_RST    = 14'd425;
	localparam logic [DUTY_W-1:0] OC_DROP_RST   = 14'd400;
	localparam logic [STEP_W-1:0] RAMP_STEP_RST = 8'd10;
	localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 14'd8075;

	// hall codes, named after the high-side and low-side phase
	localparam logic [HALL_W-1:0] HALL_AB = 3'd5;
	localparam logic [HALL_W-1:0] HALL_AC = 3'd1;
	localparam logic [HALL_W-1:0] HALL_BC = 3'd3;
	localparam logic [HALL_W-1:0] HALL_BA = 3'd2;
	localparam logic [HALL_W-1:0] HALL_CA = 3'd6;
	localparam logic [HALL_W-1:0] HALL_CB = 3'd4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_HALL        = 2'd0,
		FUNC_POT         = 2'd1,
		FUNC_OVERCURRENT = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DRIVE    = 2'd0,
		ST_LOW_DUTY = 2'd1,
		ST_BAD_HALL = 2'd2
	} status_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [HALL_W-1:0] hall;
		logic [POT_W-1:0]  pot_sample;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]   compare_a;
		logic [DUTY_W-1:0]   compare_b;
		logic [DUTY_W-1:0]   compare_c;
		logic                enable_a;
		logic                enable_b;
		logic                enable_c;
		logic [STATUS_W-1:0] status;
		logic [DUTY_W-1:0]   duty_now;
	} out_item_t;

endpackage

FILE: rtl/bldc_stream_if.sv
// Valid/ready channel carrying one payload of type T per transfer.
// No dependencies; the payload type comes from the instantiating level.
`timescale 1ns / 1ps

interface bldc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bldc_six_step_commutator.sv
// An event passes the input, product, target and result registers before its result is valid on drv.
// Throughput: one event per cycle unless drv stalls; duty and held compares update on each commit.
// Stages: input register, pot x max_duty multiply, reciprocal scale, commutation.
// Reset (arst_n low): pipeline empty, duty and held compares zero, registers at defaults.
// Depends on bldc_pkg, bldc_stream_if, bldc_commute and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bldc_six_step_commutator
	import bldc_pkg::*;
#(
	parameter int TIMER_PERIOD   = 8499,
	parameter int POT_FULL_SCALE = 4095
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bldc_stream_if.sink           evt,
	bldc_stream_if.source         drv
);

	// division by POT_FULL_SCALE as multiply by rounded-up reciprocal, exact for PROD_W bits
	localparam int PROD_W    = POT_W + DUTY_W;
	localparam int RCP_SHIFT = PROD_W + $clog2(POT_FULL_SCALE);
	localparam int RCP_W     = PROD_W + 1;
	localparam int WIDE_W    = PROD_W + RCP_W;
	localparam int QUO_W     = WIDE_W - RCP_SHIFT;
	localparam int SUM_W     = DUTY_W + 1;
	localparam logic [63:0] RCP_MULT =
		((64'd1 << RCP_SHIFT) + 64'(POT_FULL_SCALE) - 64'd1) / 64'(POT_FULL_SCALE);

	// configuration
	logic [DUTY_W-1:0] cutoff_q;
	logic [DUTY_W-1:0] drop_q;
	logic [STEP_W-1:0] ramp_q;
	logic [DUTY_W-1:0] max_q;

	// pipeline
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	in_item_t          item_s1;
	logic [FUNC_W-1:0] func_s2, func_s3;
	logic [HALL_W-1:0] hall_s2, hall_s3;
	logic [PROD_W-1:0] prod_s2;
	logic [DUTY_W-1:0] target_s3;
	out_item_t         res_s4;

	// state
	logic [DUTY_W-1:0] duty_q;
	logic [DUTY_W-1:0] held_a_q, held_b_q, held_c_q;

	logic [PROD_W-1:0] pot_mul;
	logic [WIDE_W-1:0] rcp_prod;
	logic [QUO_W-1:0]  quo;
	logic [DUTY_W-1:0] target;
	logic [SUM_W-1:0]  ramp_sum;
	logic [DUTY_W-1:0] duty_nxt;
	logic              commit;
	out_item_t         comm_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RST;
			drop_q   <= OC_DROP_RST;
			ramp_q   <= RAMP_STEP_RST;
			max_q    <= MAX_DUTY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CUTOFF:    cutoff_q <= cfg_data;
				CFG_OC_DROP:   drop_q   <= cfg_data;
				CFG_RAMP_STEP: ramp_q   <= cfg_data[STEP_W-1:0];
				CFG_MAX_DUTY:  max_q    <= cfg_data;
			endcase
		end
	end

	// a stage takes new data when it is empty or its content moves on
	assign rdy_s4    = !v_s4 || drv.ready;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign evt.ready = rdy_s1;
	assign drv.valid = v_s4;
	assign drv.data  = res_s4;
	assign commit    = v_s3 && rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= evt.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	assign pot_mul  = PROD_W'(item_s1.pot_sample) * PROD_W'(max_q);
	assign rcp_prod = WIDE_W'(prod_s2) * WIDE_W'(RCP_MULT[RCP_W-1:0]);
	assign quo      = rcp_prod[RCP_SHIFT +: QUO_W];
	assign target   = (32'(quo) > TIMER_PERIOD) ? DUTY_W'(TIMER_PERIOD) : DUTY_W'(quo);

	always_ff @(posedge clk) begin
		if (rdy_s1) item_s1 <= evt.data;
		if (rdy_s2) begin
			func_s2 <= item_s1.func;
			hall_s2 <= item_s1.hall;
			prod_s2 <= pot_mul;
		end
		if (rdy_s3) begin
			func_s3   <= func_s2;
			hall_s3   <= hall_s2;
			target_s3 <= target;
		end
		if (rdy_s4) res_s4 <= comm_res;
	end

	always_comb begin
		ramp_sum = SUM_W'(duty_q) + SUM_W'(ramp_q);
		duty_nxt = duty_q;
		case (func_s3)
			FUNC_POT: begin
				// ramp up by the full step, capped at the timer period, or jump straight down to the target
				if (duty_q < target_s3) begin
					duty_nxt = (ramp_sum > SUM_W'(TIMER_PERIOD)) ? DUTY_W'(TIMER_PERIOD)
						: ramp_sum[DUTY_W-1:0];
				end else begin
					duty_nxt = target_s3;
				end
			end
			FUNC_OVERCURRENT: begin
				duty_nxt = (duty_q > drop_q) ? duty_q - drop_q : '0;
			end
			default: ;
		endcase
	end

	bldc_commute u_commute (
		.duty   (duty_nxt),
		.cutoff (cutoff_q),
		.hall   (hall_s3),
		.held_a (held_a_q),
		.held_b (held_b_q),
		.held_c (held_c_q),
		.res    (comm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q   <= '0;
			held_a_q <= '0;
			held_b_q <= '0;
			held_c_q <= '0;
		end else if (commit) begin
			duty_q   <= duty_nxt;
			held_a_q <= comm_res.compare_a;
			held_b_q <= comm_res.compare_b;
			held_c_q <= comm_res.compare_c;
		end
	end

	`ASSERT_CLK(a_duty_range, duty_q <= DUTY_W'(TIMER_PERIOD), "duty above timer period")
	`ASSERT_CLKRST(a_off_no_enable, (drv.valid && drv.data.status != ST_DRIVE) |-> !(drv.data.enable_a || drv.data.enable_b || drv.data.enable_c), "driver enabled while off")
	`ASSERT_CLKRST(a_drive_two_phases, (drv.valid && drv.data.status == ST_DRIVE) |-> ((drv.data.enable_a + drv.data.enable_b + drv.data.enable_c) == 2'd2), "driving result without two enables")
	`ASSERT_CLKRST(a_state_hold, !commit |=> ($stable(duty_q) && $stable(held_a_q) && $stable(held_b_q) && $stable(held_c_q)), "state changed without a commit")

endmodule

FILE: rtl/bldc_commute.sv
// Six-step commutation decode: compares, enables and status from duty and hall code.
// Depends on bldc_pkg.
`timescale 1ns / 1ps

module bldc_commute
	import bldc_pkg::*;
(
	input  logic [DUTY_W-1:0] duty,
	input  logic [DUTY_W-1:0] cutoff,
	input  logic [HALL_W-1:0] hall,
	input  logic [DUTY_W-1:0] held_a,
	input  logic [DUTY_W-1:0] held_b,
	input  logic [DUTY_W-1:0] held_c,
	output out_item_t         res
);

	always_comb begin
		res           = '0;
		res.duty_now  = duty;
		res.status    = ST_DRIVE;
		// the phase left floating keeps its previous compare
		res.compare_a = held_a;
		res.compare_b = held_b;
		res.compare_c = held_c;
		if (duty < cutoff) begin
			res.compare_a = '0;
			res.compare_b = '0;
			res.compare_c = '0;
			res.status    = ST_LOW_DUTY;
		end else begin
			unique case (hall)
				HALL_AB: begin
					res.compare_a = duty;
					res.compare_b = '0;
					res.enable_a  = 1'b1;
					res.enable_b  = 1'b1;
				end
				HALL_AC: begin
					res.compare_a = duty;
					res.compare_c = '0;
					res.enable_a  = 1'b1;
					res.enable_c  = 1'b1;
				end
				HALL_BC: begin
					res.compare_b = duty;
					res.compare_c = '0;
					res.enable_b  = 1'b1;
					res.enable_c  = 1'b1;
				end
				HALL_BA: begin
					res.compare_b = duty;
					res.compare_a = '0;
					res.enable_a  = 1'b1;
					res.enable_b  = 1'b1;
				end
				HALL_CA: begin
					res.compare_c = duty;
					res.compare_a = '0;
					res.enable_a  = 1'b1;
					res.enable_c  = 1'b1;
				end
				HALL_CB: begin
					res.compare_c = duty;
					res.compare_b = '0;
					res.enable_b  = 1'b1;
					res.enable_c  = 1'b1;
				end
				default: begin
					res.compare_a = '0;
					res.compare_b = '0;
					res.compare_c = '0;
					res.status    = ST_BAD_HALL;
				end
			endcase
		end
	end

endmodule

FILE: tb/bldc_six_step_checker.sv
// Checker for the six-step commutator: predicts each drive result from the event stream.
// Depends on bldc_pkg; watches the event, drive and register-write ports of the top level.
`timescale 1ns / 1ps

module bldc_six_step_checker
	import bldc_pkg::*;
#(
	parameter int TIMER_PERIOD   = 8499,
	parameter int POT_FULL_SCALE = 4095
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  evt_valid,
	input  logic                  evt_ready,
	input  in_item_t              evt_data,
	input  logic                  drv_valid,
	input  logic                  drv_ready,
	input  out_item_t             drv_data,
	output int                    errors,
	output int                    outstanding,
	output int                    checked,
	output int                    driven
);

	logic [DUTY_W-1:0] cutoff;
	logic [DUTY_W-1:0] oc_drop;
	logic [STEP_W-1:0] ramp;
	logic [DUTY_W-1:0] max_duty;
	logic [DUTY_W-1:0] duty;
	logic [DUTY_W-1:0] held [3];
	out_item_t         drive_q [$];
	int                fail_cnt;
	int                check_cnt;
	int                drive_cnt;

	function automatic logic [DUTY_W-1:0] clamp_period(longint unsigned v);
		return (v > TIMER_PERIOD) ? DUTY_W'(TIMER_PERIOD) : DUTY_W'(v);
	endfunction

	function automatic int field_diff(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict
		out_item_t       want;
		out_item_t       got;
		logic [2:0]      en;
		status_t         st;
		int              hi;
		int              lo;
		logic [DUTY_W-1:0] target;

		if (!arst_n) begin
			cutoff    = CUTOFF_RST;
			oc_drop   = OC_DROP_RST;
			ramp      = RAMP_STEP_RST;
			max_duty  = MAX_DUTY_RST;
			duty      = '0;
			for (int i = 0; i < 3; i++) held[i] = '0;
			drive_q.delete();
			fail_cnt  = 0;
			check_cnt = 0;
			drive_cnt = 0;
		end else begin
			// compare the oldest expectation first; an event passes the pipeline registers before it comes out
			if (drv_valid && drv_ready) begin
				got = drv_data;
				if (drive_q.size() == 0) begin
					$error("drive result with no event outstanding");
					fail_cnt++;
				end else begin
					want = drive_q.pop_front();
					fail_cnt += field_diff("compare_a", want.compare_a, got.compare_a);
					fail_cnt += field_diff("compare_b", want.compare_b, got.compare_b);
					fail_cnt += field_diff("compare_c", want.compare_c, got.compare_c);
					fail_cnt += field_diff("enable_a", want.enable_a, got.enable_a);
					fail_cnt += field_diff("enable_b", want.enable_b, got.enable_b);
					fail_cnt += field_diff("enable_c", want.enable_c, got.enable_c);
					fail_cnt += field_diff("status", want.status, got.status);
					fail_cnt += field_diff("duty_now", want.duty_now, got.duty_now);
					check_cnt++;
					if (want.status == ST_DRIVE) drive_cnt++;
				end
			end

			if (evt_valid && evt_ready) begin
				case (evt_data.func)
					FUNC_POT: begin
						target = clamp_period((longint'(evt_data.pot_sample) * max_duty)
							/ POT_FULL_SCALE);
						if (duty < target) duty = clamp_period(longint'(duty) + ramp);
						else duty = target;
					end
					FUNC_OVERCURRENT: duty = (duty > oc_drop) ? duty - oc_drop : '0;
					default: ;
				endcase

				en = '0;
				hi = 0;
				lo = 0;
				st = ST_DRIVE;
				if (duty < cutoff) begin
					st = ST_LOW_DUTY;
				end else begin
					case (evt_data.hall)
						HALL_AB: begin hi = 0; lo = 1; end
						HALL_AC: begin hi = 0; lo = 2; end
						HALL_BC: begin hi = 1; lo = 2; end
						HALL_BA: begin hi = 1; lo = 0; end
						HALL_CA: begin hi = 2; lo = 0; end
						HALL_CB: begin hi = 2; lo = 1; end
						default: st = ST_BAD_HALL;
					endcase
				end

				if (st != ST_DRIVE) begin
					for (int i = 0; i < 3; i++) held[i] = '0;
				end else begin
					// the third phase keeps whatever an earlier event left in it
					held[hi] = duty;
					held[lo] = '0;
					en[hi]   = 1'b1;
					en[lo]   = 1'b1;
				end

				want.compare_a = held[0];
				want.compare_b = held[1];
				want.compare_c = held[2];
				want.enable_a  = en[0];
				want.enable_b  = en[1];
				want.enable_c  = en[2];
				want.status    = st;
				want.duty_now  = duty;
				drive_q.push_back(want);
			end

			if (cfg_we) begin
				case (cfg_index)
					CFG_CUTOFF:    cutoff   = cfg_data;
					CFG_OC_DROP:   oc_drop  = cfg_data;
					CFG_RAMP_STEP: ramp     = cfg_data[STEP_W-1:0];
					CFG_MAX_DUTY:  max_duty = cfg_data;
					default: ;
				endcase
			end
		end

		errors      <= fail_cnt;
		outstanding <= drive_q.size();
		checked     <= check_cnt;
		driven      <= drive_cnt;
	end

endmodule

FILE: tb/bldc_six_step_commutator_tb.sv
// Top of the commutator testbench: clock, reset, register writes, event and drive traffic.
// Depends on bldc_pkg, bldc_stream_if, bldc_six_step_commutator and bldc_six_step_checker.
`timescale 1ns / 1ps

module bldc_six_step_commutator_tb;
	import bldc_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;
	localparam logic [HALL_W-1:0] HALL_OFF_LO = 3'd0;
	localparam logic [HALL_W-1:0] HALL_OFF_HI = 3'd7;
	localparam int                N_PHASES    = 6;
	localparam int                PHASE_ITEMS = 138;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_CHOKE} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    outstanding;
	int                    checked;
	int                    driven;
	int                    sent;
	rx_mode_t              rx_mode = RX_OPEN;
	int unsigned           rx_left = 0;
	logic [HALL_W-1:0]     hall_order [6] = '{HALL_AB, HALL_AC, HALL_BC, HALL_BA, HALL_CA,
		HALL_CB};

	bldc_stream_if #(.T(in_item_t))  evt_ch ();
	bldc_stream_if #(.T(out_item_t)) drv_ch ();

	bldc_six_step_commutator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt       (evt_ch.sink),
		.drv       (drv_ch.source)
	);

	bldc_six_step_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.evt_valid   (evt_ch.valid),
		.evt_ready   (evt_ch.ready),
		.evt_data    (evt_ch.data),
		.drv_valid   (drv_ch.valid),
		.drv_ready   (drv_ch.ready),
		.drv_data    (drv_ch.data),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.driven      (driven)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: switch between open, random, periodic and choked windows
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(8, 60);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:    drv_ch.ready <= 1'b1;
			RX_RANDOM:  drv_ch.ready <= ($urandom_range(0, 3) != 0);
			RX_PATTERN: drv_ch.ready <= rx_left[1] ^ rx_left[3];
			default:    drv_ch.ready <= (rx_left % 7 == 0);
		endcase
	end

	function automatic in_item_t mk_event(logic [FUNC_W-1:0] f, logic [HALL_W-1:0] h,
		logic [POT_W-1:0] p);
		in_item_t it;
		it.func       = f;
		it.hall       = h;
		it.pot_sample = p;
		return it;
	endfunction

	task automatic send(in_item_t it);
		evt_ch.valid <= 1'b1;
		evt_ch.data  <= it;
		do @(posedge clk); while (!evt_ch.ready);
		sent++;
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// drain: hold off until every transfer in flight has come out
	task automatic settle();
		evt_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_regs(logic [CFG_DATA_W-1:0] c, logic [CFG_DATA_W-1:0] d,
		logic [CFG_DATA_W-1:0] s, logic [CFG_DATA_W-1:0] m);
		logic [CFG_IDX_W-1:0]  idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		idx = '{CFG_CUTOFF, CFG_OC_DROP, CFG_RAMP_STEP, CFG_MAX_DUTY};
		val = '{c, d, s, m};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// mostly rotor-order hall sequences with pot ramps; the rest is noise
	task automatic run_phase(int n_items);
		int       pos;
		int       left;
		int       burst;
		int       roll;
		int       sub;
		in_item_t it;
		pos  = $urandom_range(0, 5);
		left = n_items;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			if (burst > left) burst = left;
			repeat (burst) begin
				roll          = $urandom_range(0, 99);
				it.pot_sample = POT_W'($urandom());
				it.hall       = hall_order[pos];
				if (roll < 55) begin
					it.func = FUNC_POT;
					sub     = $urandom_range(0, 9);
					if (sub == 0) it.pot_sample = '0;
					else if (sub == 1) it.pot_sample = '1;
					else if (sub > 3) it.pot_sample = POT_W'($urandom_range(2048, 4095));
				end else if (roll < 80) begin
					it.func = FUNC_HALL;
					sub     = $urandom_range(0, 19);
					if (sub < 17) pos = (pos + 1) % 6;
					else if (sub < 19) pos = (pos + 5) % 6;
					it.hall = hall_order[pos];
				end else if (roll < 88) begin
					it.func = FUNC_HALL;
					it.hall = HALL_W'($urandom_range(0, 7));
				end else if (roll < 95) begin
					it.func = FUNC_OVERCURRENT;
				end else begin
					it.func = FUNC_SPARE;
					it.hall = HALL_W'($urandom_range(0, 7));
				end
				send(it);
			end
			left -= burst;
			if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
		end
		settle();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		evt_ch.valid = 1'b0;
		evt_ch.data  = '0;
		sent         = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: duty zero sits below the cutoff, even for a bad hall code
		send(mk_event(FUNC_HALL, HALL_AB, '0));
		send(mk_event(FUNC_HALL, HALL_OFF_LO, '0));
		send(mk_event(FUNC_OVERCURRENT, HALL_OFF_HI, '1));
		send(mk_event(FUNC_POT, HALL_AB, '0));
		send(mk_event(FUNC_POT, HALL_AC, '1));
		send(mk_event(FUNC_SPARE, HALL_AB, '1));
		settle();

		// zero cutoff so every valid code commutates, saturating max duty
		write_regs('0, OC_DROP_RST, 14'd255, '1);
		for (int i = 0; i < 6; i++) send(mk_event(FUNC_HALL, hall_order[i], 12'h555));
		for (int i = 0; i < 4; i++) send(mk_event(FUNC_POT, hall_order[i], '1));
		send(mk_event(FUNC_HALL, HALL_OFF_LO, 12'haaa));
		send(mk_event(FUNC_HALL, HALL_OFF_HI, '0));
		send(mk_event(FUNC_POT, HALL_CA, '1));
		send(mk_event(FUNC_OVERCURRENT, HALL_CA, '0));
		send(mk_event(FUNC_POT, HALL_CB, 12'd2048));
		send(mk_event(FUNC_POT, HALL_CB, '0));
		send(mk_event(FUNC_SPARE, HALL_BC, '1));
		settle();

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: write_regs('0, 14'd8499, 14'd255, 14'd8499);
				1: write_regs(14'd8499, '0, 14'd1, '0);
				2: write_regs('1, '1, '1, '1);
				3: write_regs(CUTOFF_RST, OC_DROP_RST, RAMP_STEP_RST, MAX_DUTY_RST);
				default: write_regs(CFG_DATA_W'($urandom_range(0, 2000)),
					CFG_DATA_W'($urandom_range(0, 1500)),
					CFG_DATA_W'($urandom_range(0, 255)),
					CFG_DATA_W'($urandom_range(0, 16383)));
			endcase
			run_phase(PHASE_ITEMS);
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d events (every event kind, valid and invalid hall codes) over %0d",
			sent, N_PHASES + 2);
		$display("register settings; %0d drive results checked, %0d with a phase pair on.",
			checked, driven);
		if (errors == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
